[hw/rtl/kfd_pkg.sv]
// ----------------------------------------------------------------------------
// KISS deframer package
// Shared types and constants for the KISS frame deframer.
// ----------------------------------------------------------------------------
package kfd_pkg;

  localparam int unsigned CountW = 10;

  localparam logic [7:0] KissEnd  = 8'hC0;
  localparam logic [7:0] KissEsc  = 8'hDB;
  localparam logic [7:0] KissTEnd = 8'hDC;
  localparam logic [7:0] KissTEsc = 8'hDD;
  localparam logic [3:0] CmdData  = 4'h0;

  localparam logic [CountW-1:0] LimitReset = CountW'(512);

  typedef struct packed {
    logic [CountW-1:0] raw_count;
    logic              escape_pending;
    logic              data_frame;
  } kfd_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       frame_abort;
  } kfd_result_t;

endpackage

[hw/rtl/kfd_in_if.sv]
// ----------------------------------------------------------------------------
// KISS deframer raw byte channel
// Valid/ready channel that carries one raw byte from the serial link.
// ----------------------------------------------------------------------------
interface kfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[hw/rtl/kfd_out_if.sv]
// ----------------------------------------------------------------------------
// KISS deframer result channel
// Valid/ready channel that carries one unescaped payload result.
// ----------------------------------------------------------------------------
interface kfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       frame_end;
  logic       frame_abort;

  modport source (output valid, output out_byte, output byte_valid, output frame_end,
                  output frame_abort, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input frame_end,
                input frame_abort, output ready);
endinterface

[hw/rtl/kfd_step.sv]
// ----------------------------------------------------------------------------
// KISS deframer step logic
// Next frame state and optional result for one raw byte.
// ----------------------------------------------------------------------------
module kfd_step (
  input  kfd_pkg::kfd_state_t              state_i,
  input  logic [7:0]                       in_byte_i,
  input  logic [kfd_pkg::CountW-1:0]       limit_i,
  output kfd_pkg::kfd_state_t              state_o,
  output kfd_pkg::kfd_result_t             result_o,
  output logic                             result_valid_o
);
  import kfd_pkg::*;

  logic [CountW:0] next_count;

  assign next_count = {1'b0, state_i.raw_count} + (CountW+1)'(1);

  always_comb begin
    state_o        = state_i;
    result_o       = '0;
    result_valid_o = 1'b0;
    if (in_byte_i == KissEnd) begin
      if (state_i.raw_count != '0) begin
        state_o = '0;
        if (state_i.data_frame) begin
          result_valid_o      = 1'b1;
          result_o.frame_end  = 1'b1;
          result_o.byte_valid = state_i.escape_pending;
          result_o.out_byte   = state_i.escape_pending ? KissEsc : 8'h00;
        end
      end
    end else if (next_count > {1'b0, limit_i}) begin
      // drop the overflowing byte and restart framing
      state_o = '0;
      if (state_i.data_frame) begin
        result_valid_o       = 1'b1;
        result_o.frame_abort = 1'b1;
      end
    end else begin
      state_o.raw_count = next_count[CountW-1:0];
      if (state_i.raw_count == '0) begin
        state_o.data_frame     = (in_byte_i[3:0] == CmdData);
        state_o.escape_pending = 1'b0;
      end else if (state_i.data_frame) begin
        if (state_i.escape_pending) begin
          state_o.escape_pending = 1'b0;
          result_valid_o         = 1'b1;
          result_o.byte_valid    = 1'b1;
          case (in_byte_i)
            KissTEnd: result_o.out_byte = KissEnd;
            KissTEsc: result_o.out_byte = KissEsc;
            default:  result_o.out_byte = in_byte_i;
          endcase
        end else if (in_byte_i == KissEsc) begin
          state_o.escape_pending = 1'b1;
        end else begin
          result_valid_o      = 1'b1;
          result_o.byte_valid = 1'b1;
          result_o.out_byte   = in_byte_i;
        end
      end
    end
  end

endmodule

[hw/rtl/kiss_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// KISS frame deframer core
// Result: a result is registered in the result register in the cycle after its byte is accepted.
// Throughput: one raw byte per cycle; input stalls only while a result waits
// in the result register and the sink is not ready.
// Reset: frame state clears, the limit returns to 512, no result is pending.
// ----------------------------------------------------------------------------
module kiss_frame_deframer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kfd_pkg::CountW-1:0]  cfg_wdata_i,
  kfd_in_if.sink                      rx_i,
  kfd_out_if.source                   tx_o
);
  import kfd_pkg::*;

  kfd_state_t        state_q, state_d;
  kfd_result_t       res_q, res_d;
  logic              res_valid_q;
  logic              step_valid;
  logic [CountW-1:0] limit_q;
  logic              accept;

  assign rx_i.ready = !res_valid_q || tx_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  kfd_step u_step (
    .state_i        (state_q),
    .in_byte_i      (rx_i.in_byte),
    .limit_i        (limit_q),
    .state_o        (state_d),
    .result_o       (res_d),
    .result_valid_o (step_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (rx_i.ready) begin
        res_valid_q <= accept && step_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && step_valid) begin
      res_q <= res_d;
    end
  end

  assign tx_o.valid       = res_valid_q;
  assign tx_o.out_byte    = res_q.out_byte;
  assign tx_o.byte_valid  = res_q.byte_valid;
  assign tx_o.frame_end   = res_q.frame_end;
  assign tx_o.frame_abort = res_q.frame_abort;

endmodule

[hw/rtl/kfd_checker.sv]
// ----------------------------------------------------------------------------
// KISS deframer port checker
// Port-level properties of the deframer core, attached by bind.
// ----------------------------------------------------------------------------
module kfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic       frame_end_i,
  input logic       frame_abort_i
);

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(byte_valid_i) && $stable(frame_end_i) && $stable(frame_abort_i))
    else $error("stalled item changed");

  a_abort_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_abort_i |-> !byte_valid_i && !frame_end_i && out_byte_i == 8'h00)
    else $error("abort carries other fields");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> byte_valid_i || frame_end_i || frame_abort_i)
    else $error("empty item delivered");

  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> out_byte_i == 8'h00)
    else $error("byte set without byte_valid");

endmodule

bind kiss_frame_deframer_core kfd_checker u_kfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (rx_i.ready),
  .out_valid_i   (tx_o.valid),
  .out_ready_i   (tx_o.ready),
  .out_byte_i    (tx_o.out_byte),
  .byte_valid_i  (tx_o.byte_valid),
  .frame_end_i   (tx_o.frame_end),
  .frame_abort_i (tx_o.frame_abort)
);
